// File: rtl/core/pnu_pkg.sv
// Shared types and constants of the palette nearest-neighbour upscaler.
package pnu_pkg;

    // Parameter defaults
    localparam int LINE_MAX_DEF      = 512;
    localparam int MAX_SCALE_DEF     = 8;
    localparam int PALETTE_DEPTH_DEF = 256;
    localparam int COLOR_BITS_DEF    = 32;

    // Fixed field widths
    localparam int CMD_W   = 2;
    localparam int CODE_W  = 8;
    localparam int COLOR_W = 32;
    localparam int RUN_W   = 5;     // run length, covers a scale of up to 16
    localparam int COL_W   = 10;
    localparam int ROW_W   = 10;
    localparam int REP_W   = 3;
    localparam int SCALE_W = 4;
    localparam int CFG_W   = 10;
    localparam int CIDX_W  = 2;

    // Input commands
    typedef logic [CMD_W-1:0] cmd_t;
    localparam cmd_t CMD_PALETTE = 2'd0;
    localparam cmd_t CMD_PIXEL   = 2'd1;
    localparam cmd_t CMD_REPLAY  = 2'd2;

    // Item kinds inside the pipeline
    typedef logic [1:0] kind_t;
    localparam kind_t KIND_WRITE  = 2'd0;
    localparam kind_t KIND_PIXEL  = 2'd1;
    localparam kind_t KIND_REPLAY = 2'd2;
    localparam kind_t KIND_ERROR  = 2'd3;

    // Configuration register indexes
    typedef logic [CIDX_W-1:0] cfg_idx_t;
    localparam cfg_idx_t CFG_SCALE  = 2'd0;
    localparam cfg_idx_t CFG_WIDTH  = 2'd1;
    localparam cfg_idx_t CFG_HEIGHT = 2'd2;

    // Register reset values
    localparam logic [SCALE_W-1:0] SCALE_RST  = 4'd1;
    localparam logic [CFG_W-1:0]   WIDTH_RST  = 10'd320;
    localparam logic [CFG_W-1:0]   HEIGHT_RST = 10'd200;

    // One run of identical output pixels
    typedef struct packed {
        logic [COLOR_W-1:0] color;
        logic [RUN_W-1:0]   len;
        logic               eol;
        logic               eof;
        logic               err;
    } run_t;

endpackage

// File: rtl/core/pnu_run_emit.sv
// Run emitter: repeats one colour for a run of output items, doubles as output register.
module pnu_run_emit
    import pnu_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               load_valid,
    output logic               load_ready,
    input  run_t               load_run,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [COLOR_W-1:0] m_tdata,   // color_out
    output logic               m_tlast,   // last_of_run
    output logic [2:0]         m_tuser    // end_of_line, end_of_frame, error
);

    logic             busy_reg, busy_next;
    logic [RUN_W-1:0] left_reg, left_next;
    run_t             run_reg;
    logic             last_copy;
    logic             load;

    assign last_copy  = (left_reg == RUN_W'(1));
    assign load_ready = !busy_reg || (m_tready && last_copy);
    assign load       = load_valid && load_ready;

    always_comb
    begin
        busy_next = busy_reg;
        left_next = left_reg;
        if (load)
        begin
            busy_next = 1'b1;
            left_next = load_run.len;
        end
        else if (busy_reg && m_tready)
        begin
            busy_next = !last_copy;
            left_next = left_reg - RUN_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            left_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            left_reg <= left_next;
        end
    end

    // hold the run payload until the last copy leaves
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            run_reg <= load_run;
        end
    end

    assign m_tvalid = busy_reg;
    assign m_tdata  = run_reg.color;
    assign m_tlast  = last_copy && !run_reg.err;
    assign m_tuser  = {run_reg.err, run_reg.eof && last_copy, run_reg.eol && last_copy};

endmodule

// File: rtl/core/palette_nearest_neighbor_upscaler_unit.sv
// Top level of the palette nearest-neighbour upscaler.
//
//  channel  | direction | handshake            | payload
//  ---------+-----------+----------------------+---------------------------------------
//  s_axis   | in        | s_tvalid / s_tready  | s_tdata {color_in, code}, s_tuser command
//  m_axis   | out       | m_tvalid / m_tready  | m_tdata color_out, m_tlast, m_tuser flags
//  cfg      | in        | cfg_valid/cfg_ready  | cfg_index, cfg_data
//
// A pixel or replay item occupies the output for scale copies, one copy a cycle
// while m_tready holds high, so the run emitter at the output paces the input; a
// palette write leaves stage 1 without waiting for the output. The first copy leaves
// after the line store read, the palette read and the emitter load, in that order.
// Reset clears the control state and the configuration registers; memories need no clearing pass.
// A stall at the output holds every stage but a palette write in stage 1; the emitter loads
// the next run as the last copy of the current one is taken, so runs follow without a gap.
module palette_nearest_neighbor_upscaler_unit
    import pnu_pkg::*;
#(
    parameter int LINE_MAX      = LINE_MAX_DEF,
    parameter int MAX_SCALE     = MAX_SCALE_DEF,
    parameter int PALETTE_DEPTH = PALETTE_DEPTH_DEF,
    parameter int COLOR_BITS    = COLOR_BITS_DEF
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [CODE_W+COLOR_W-1:0] s_tdata,   // code [7:0], color_in [39:8]
    input  logic [CMD_W-1:0]          s_tuser,   // command
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [COLOR_W-1:0]        m_tdata,   // color_out
    output logic                      m_tlast,   // last_of_run
    output logic [2:0]                m_tuser,   // end_of_line, end_of_frame, error
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [CIDX_W-1:0]         cfg_index,
    input  logic [CFG_W-1:0]          cfg_data
);

    localparam int LAW = $clog2(LINE_MAX);
    localparam int PAW = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
    localparam int WCW = ($clog2(LINE_MAX + 1) > COL_W + 1) ? $clog2(LINE_MAX + 1)
                                                             : COL_W + 1;

    // Configuration registers
    logic [SCALE_W-1:0] scale_reg;
    logic [CFG_W-1:0]   width_reg;
    logic [CFG_W-1:0]   height_reg;

    // Frame position
    logic [COL_W-1:0] column_reg, column_next;
    logic [ROW_W-1:0] row_reg, row_next;
    logic [REP_W-1:0] repeat_reg, repeat_next;
    logic             phase_reg, phase_next;

    // Memories
    logic [CODE_W-1:0]     line_mem [LINE_MAX];
    logic [COLOR_BITS-1:0] pal_mem  [PALETTE_DEPTH];
    logic [CODE_W-1:0]     ls_rd_reg;
    logic [COLOR_BITS-1:0] pal_rd_reg;

    // Stage 1: decoded item
    logic               s1_valid_reg;
    kind_t              s1_kind_reg;
    logic [CODE_W-1:0]  s1_code_reg;
    logic [COLOR_W-1:0] s1_color_reg;
    logic [RUN_W-1:0]   s1_len_reg;
    logic               s1_eol_reg;
    logic               s1_eof_reg;
    logic               s1_blank_reg;

    // Stage 2: palette data
    logic             s2_valid_reg;
    logic             s2_err_reg;
    logic             s2_hit_reg;
    logic [RUN_W-1:0] s2_len_reg;
    logic             s2_eol_reg;
    logic             s2_eof_reg;

    logic [CODE_W-1:0]  in_code;
    logic [COLOR_W-1:0] in_color;
    logic               accept;
    logic [RUN_W-1:0]   eff_scale;
    logic [WCW-1:0]     eff_width;
    logic [ROW_W:0]     eff_height;
    logic               eol;
    logic               last_src;
    logic               last_rep;
    logic               col_in_line;
    kind_t              kind;
    logic               eof;
    logic               s1_adv;
    logic               s2_free;
    logic               emit_ready;
    logic [CODE_W-1:0]  look_code;
    logic               look_in_pal;
    run_t               run;

    assign in_code   = s_tdata[CODE_W-1:0];
    assign in_color  = s_tdata[CODE_W+COLOR_W-1:CODE_W];
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_reg  <= SCALE_RST;
            width_reg  <= WIDTH_RST;
            height_reg <= HEIGHT_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_SCALE:  scale_reg  <= cfg_data[SCALE_W-1:0];
                CFG_WIDTH:  width_reg  <= cfg_data;
                CFG_HEIGHT: height_reg <= cfg_data;
                default:    ;
            endcase
        end
    end

    // Clamp the registers to their working ranges
    always_comb
    begin
        if (scale_reg == '0)
            eff_scale = RUN_W'(1);
        else if (int'(scale_reg) > MAX_SCALE)
            eff_scale = RUN_W'(MAX_SCALE);
        else
            eff_scale = RUN_W'(scale_reg);

        if (width_reg == '0)
            eff_width = WCW'(1);
        else if (int'(width_reg) > LINE_MAX)
            eff_width = WCW'(LINE_MAX);
        else
            eff_width = WCW'(width_reg);

        eff_height = (height_reg == '0) ? (ROW_W + 1)'(1) : {1'b0, height_reg};
    end

    assign eol         = (WCW'(column_reg) + WCW'(1)) >= eff_width;
    assign last_src    = ((ROW_W + 1)'(row_reg) + (ROW_W + 1)'(1)) >= eff_height;
    assign last_rep    = ((RUN_W + 1)'(repeat_reg) + (RUN_W + 1)'(2)) >= (RUN_W + 1)'(eff_scale);
    assign col_in_line = int'(column_reg) < LINE_MAX;

    // Decode the command against the phase
    always_comb
    begin
        case (s_tuser)
            CMD_PALETTE: kind = KIND_WRITE;
            CMD_PIXEL:   kind = phase_reg ? KIND_ERROR : KIND_PIXEL;
            CMD_REPLAY:  kind = phase_reg ? KIND_REPLAY : KIND_ERROR;
            default:     kind = KIND_ERROR;
        endcase
    end

    assign eof = eol && last_src &&
                 ((kind == KIND_PIXEL) ? (eff_scale == RUN_W'(1)) : last_rep);

    // Pipeline control
    assign s2_free  = !s2_valid_reg || emit_ready;
    assign s1_adv   = s1_valid_reg && ((s1_kind_reg == KIND_WRITE) || s2_free);
    assign s_tready = !s1_valid_reg || s1_adv;
    assign accept   = s_tvalid && s_tready;

    // Advance the frame position
    always_comb
    begin
        column_next = column_reg;
        row_next    = row_reg;
        repeat_next = repeat_reg;
        phase_next  = phase_reg;
        if (accept && (kind == KIND_PIXEL || kind == KIND_REPLAY))
        begin
            column_next = eol ? '0 : column_reg + COL_W'(1);
            if (eol)
            begin
                if (kind == KIND_PIXEL)
                begin
                    if (eff_scale > RUN_W'(1))
                    begin
                        phase_next  = 1'b1;
                        repeat_next = '0;
                    end
                    else
                    begin
                        row_next = last_src ? '0 : row_reg + ROW_W'(1);
                    end
                end
                else if (last_rep)
                begin
                    phase_next  = 1'b0;
                    repeat_next = '0;
                    row_next    = last_src ? '0 : row_reg + ROW_W'(1);
                end
                else
                begin
                    repeat_next = repeat_reg + REP_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            column_reg <= '0;
            row_reg    <= '0;
            repeat_reg <= '0;
            phase_reg  <= 1'b0;
        end
        else
        begin
            column_reg <= column_next;
            row_reg    <= row_next;
            repeat_reg <= repeat_next;
            phase_reg  <= phase_next;
        end
    end

    // Line store: write pixels, read back for replay, both at acceptance
    always_ff @(posedge clk)
    begin
        if (accept && kind == KIND_PIXEL && col_in_line)
        begin
            line_mem[LAW'(column_reg)] <= in_code;
        end
        if (accept && kind == KIND_REPLAY)
        begin
            ls_rd_reg <= line_mem[LAW'(column_reg)];
        end
    end

    // Stage 1 registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            s1_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_kind_reg  <= kind;
            s1_code_reg  <= in_code;
            s1_color_reg <= in_color;
            s1_len_reg   <= (kind == KIND_ERROR) ? RUN_W'(1) : eff_scale;
            s1_eol_reg   <= eol && kind != KIND_ERROR;
            s1_eof_reg   <= eof && kind != KIND_ERROR;
            s1_blank_reg <= !col_in_line;
        end
    end

    // Palette: all writes and reads in item order at the stage 1 advance.
    // A replay slot beyond the line store holds code zero.
    assign look_code   = (s1_kind_reg != KIND_REPLAY) ? s1_code_reg :
                         s1_blank_reg                 ? '0 : ls_rd_reg;
    assign look_in_pal = int'(look_code) < PALETTE_DEPTH;

    always_ff @(posedge clk)
    begin
        if (s1_adv && s1_kind_reg == KIND_WRITE && look_in_pal)
        begin
            pal_mem[PAW'(look_code)] <= s1_color_reg[COLOR_BITS-1:0];
        end
        if (s1_adv && (s1_kind_reg == KIND_PIXEL || s1_kind_reg == KIND_REPLAY))
        begin
            pal_rd_reg <= pal_mem[PAW'(look_code)];
        end
    end

    // Stage 2 registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (s1_adv && s1_kind_reg != KIND_WRITE)
        begin
            s2_valid_reg <= 1'b1;
        end
        else if (emit_ready)
        begin
            s2_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv && s1_kind_reg != KIND_WRITE)
        begin
            s2_err_reg <= (s1_kind_reg == KIND_ERROR);
            s2_hit_reg <= look_in_pal;
            s2_len_reg <= s1_len_reg;
            s2_eol_reg <= s1_eol_reg;
            s2_eof_reg <= s1_eof_reg;
        end
    end

    always_comb
    begin
        run.color = (s2_hit_reg && !s2_err_reg) ? COLOR_W'(pal_rd_reg) : '0;
        run.len   = s2_len_reg;
        run.eol   = s2_eol_reg;
        run.eof   = s2_eof_reg;
        run.err   = s2_err_reg;
    end

    pnu_run_emit u_emit
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .load_valid (s2_valid_reg),
        .load_ready (emit_ready),
        .load_run   (run),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .m_tuser    (m_tuser)
    );

    // A stalled stage 1 item keeps its kind
    a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !s1_adv |=> s1_valid_reg && $stable(s1_kind_reg))
        else $error("stage 1 item changed while stalled");

    // Outside replay the repeat counter rests at zero
    a_rep_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !phase_reg |-> repeat_reg == '0)
        else $error("repeat counter not cleared outside replay");

    // An error result is a single item and never closes a run
    a_err_len: assert property (@(posedge clk) disable iff (!rst_n)
        s2_valid_reg && s2_err_reg |-> s2_len_reg == RUN_W'(1) && !s2_eol_reg && !s2_eof_reg)
        else $error("error item with run flags or length");

    a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[2] |-> !m_tlast && m_tuser[1:0] == 2'b00)
        else $error("error result carries end flags");

endmodule

// File: test/palette_nearest_neighbor_upscaler_unit_tb.sv
// Self-checking testbench for the palette nearest-neighbour upscaler.
module palette_nearest_neighbor_upscaler_unit_tb;
    import pnu_pkg::*;

    // Command 3 has no meaning in the block and must always be rejected
    localparam cmd_t CMD_UNUSED = 2'd3;

    // Cycles to let pass once nothing is expected: three stages plus margin, since a
    // palette write leaves no trace at the output
    localparam int SETTLE_CYCLES = 8;

    // One output pixel as the checker sees it
    typedef struct packed {
        logic [COLOR_W-1:0] color;
        logic               last;
        logic               eol;
        logic               eof;
        logic               err;
    } pixel_out_t;

    logic                      clk;
    logic                      rst_n     = 1'b0;
    logic                      s_tvalid  = 1'b0;
    logic                      s_tready;
    logic [CODE_W+COLOR_W-1:0] s_tdata   = '0;   // code [7:0], color_in [39:8]
    logic [CMD_W-1:0]          s_tuser   = '0;   // command
    logic                      m_tvalid;
    logic                      m_tready  = 1'b0;
    logic [COLOR_W-1:0]        m_tdata;          // color_out
    logic                      m_tlast;          // last_of_run
    logic [2:0]                m_tuser;          // end_of_line, end_of_frame, error
    logic                      cfg_valid = 1'b0;
    logic                      cfg_ready;
    logic [CIDX_W-1:0]         cfg_index = '0;
    logic [CFG_W-1:0]          cfg_data  = '0;

    // Shadow of the block: registers, memories and scan position
    logic [SCALE_W-1:0] reg_scale  = SCALE_RST;
    logic [CFG_W-1:0]   reg_width  = WIDTH_RST;
    logic [CFG_W-1:0]   reg_height = HEIGHT_RST;
    logic [COLOR_W-1:0] palette_copy [PALETTE_DEPTH_DEF];
    logic [CODE_W-1:0]  line_copy [LINE_MAX_DEF];
    bit                 slot_loaded [PALETTE_DEPTH_DEF];
    logic [CODE_W-1:0]  loaded_codes [$];
    int unsigned        scan_col   = 0;
    int unsigned        scan_row   = 0;
    int unsigned        repeat_idx = 0;
    bit                 replaying  = 1'b0;

    pixel_out_t         expected_pixels [$];

    // Idling control: calm sides never pause
    bit                 src_calm  = 1'b0;
    bit                 snk_calm  = 1'b0;
    int unsigned        sink_wait = 0;

    int unsigned        items_sent     = 0;
    int unsigned        pixels_checked = 0;
    int unsigned        rejects_seen   = 0;
    int unsigned        settings_used  = 0;
    int unsigned        mismatches     = 0;

    palette_nearest_neighbor_upscaler_unit u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Hard stop, well beyond the slowest legal run
    initial
    begin
        #10_000_000;
        $display("FAIL palette_nearest_neighbor_upscaler_unit");
        $finish;
    end

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    // Queue one run of identical pixels; only the final copy carries the row and
    // frame marks
    task automatic queue_run(logic [COLOR_W-1:0] shade, int unsigned copies,
                             bit row_end, bit frame_end);
        pixel_out_t  px;
        int unsigned k;
        for (k = 0; k < copies; k++)
        begin
            px.color = shade;
            px.last  = (k + 1 == copies);
            px.eol   = px.last && row_end;
            px.eof   = px.last && frame_end;
            px.err   = 1'b0;
            expected_pixels.push_back(px);
        end
    endtask

    // Advance the shadow by one accepted item and queue the pixels it produces
    task automatic predict_upscale(cmd_t cmd, logic [CODE_W-1:0] code,
                                   logic [COLOR_W-1:0] color);
        int unsigned scale;
        int unsigned width;
        int unsigned height;
        bit          row_end;
        bit          last_row;
        bit          last_rep;
        pixel_out_t  reject;
        // Clamp the registers to what the datapath can honour
        scale  = (reg_scale == 0) ? 1 :
                 (reg_scale > MAX_SCALE_DEF) ? MAX_SCALE_DEF : reg_scale;
        width  = (reg_width == 0) ? 1 :
                 (reg_width > LINE_MAX_DEF) ? LINE_MAX_DEF : reg_width;
        height = (reg_height == 0) ? 1 : reg_height;
        row_end  = (scan_col + 1 >= width);
        last_row = (scan_row + 1 >= height);
        last_rep = (repeat_idx + 2 >= scale);

        if (cmd == CMD_PALETTE)
        begin
            palette_copy[code] = color;
            if (!slot_loaded[code])
                loaded_codes.push_back(code);
            slot_loaded[code] = 1'b1;
        end
        else if (cmd == CMD_PIXEL && !replaying)
        begin
            if (scan_col < LINE_MAX_DEF)
                line_copy[scan_col] = code;
            queue_run(palette_copy[code], scale, row_end, row_end && last_row && scale == 1);
            if (row_end)
            begin
                scan_col = 0;
                if (scale > 1)
                begin
                    replaying  = 1'b1;
                    repeat_idx = 0;
                end
                else
                    scan_row = last_row ? 0 : (scan_row + 1) & 10'h3ff;
            end
            else
                scan_col = (scan_col + 1) & 10'h3ff;
        end
        else if (cmd == CMD_REPLAY && replaying)
        begin
            queue_run(palette_copy[line_copy[scan_col]], scale, row_end,
                      row_end && last_row && last_rep);
            if (row_end)
            begin
                scan_col = 0;
                if (last_rep)
                begin
                    replaying  = 1'b0;
                    repeat_idx = 0;
                    scan_row   = last_row ? 0 : (scan_row + 1) & 10'h3ff;
                end
                else
                    repeat_idx = (repeat_idx + 1) & 3'h7;
            end
            else
                scan_col = (scan_col + 1) & 10'h3ff;
        end
        else
        begin
            // Wrong phase or unused command: one flagged pixel, nothing else moves
            reject     = '0;
            reject.err = 1'b1;
            expected_pixels.push_back(reject);
        end
    endtask

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Present one item after a random gap; hold valid high when no gap is drawn so
    // back-to-back items see no bubble
    task automatic send_item(cmd_t cmd, logic [CODE_W-1:0] code, logic [COLOR_W-1:0] color);
        int unsigned gap;
        gap = src_calm ? 0 : $urandom_range(0, 19);
        if (gap != 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {color, code};
        s_tuser  <= cmd;
        do
            @(posedge clk);
        while (s_tready !== 1'b1);
        predict_upscale(cmd, code, color);
        items_sent++;
    endtask

    // Pick a palette slot that has been loaded, so no read hits an unwritten entry
    function automatic logic [CODE_W-1:0] pick_code();
        return loaded_codes[$urandom_range(0, loaded_codes.size() - 1)];
    endfunction

    // Drop valid and hold off until every queued pixel has been taken
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (expected_pixels.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write one register; valid stays high so writes can follow back to back
    task automatic put_register(cfg_idx_t idx, logic [CFG_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (cfg_ready !== 1'b1);
        case (idx)
            CFG_SCALE:  reg_scale  = value[SCALE_W-1:0];
            CFG_WIDTH:  reg_width  = value;
            CFG_HEIGHT: reg_height = value;
            default: ;
        endcase
    endtask

    // Reprogram the block once idle. Keep the width while a line is being replayed:
    // a wider line would replay slots this line never filled.
    task automatic configure(logic [CFG_W-1:0] scale, logic [CFG_W-1:0] width,
                             logic [CFG_W-1:0] height);
        wait_drained();
        put_register(CFG_SCALE, scale);
        if (!replaying)
            put_register(CFG_WIDTH, width);
        put_register(CFG_HEIGHT, height);
        cfg_valid <= 1'b0;
        settings_used++;
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Load the palette, including both end slots and both extreme colours, then run
    // two pixels under the reset settings
    task automatic test_reset_settings();
        int unsigned n;
        send_item(CMD_PALETTE, 8'h00, 32'h0000_0000);
        send_item(CMD_PALETTE, 8'hff, 32'hffff_ffff);
        for (n = 0; n < 6; n++)
            send_item(CMD_PALETTE, CODE_W'($urandom), $urandom);
        send_item(CMD_PIXEL, 8'h00, $urandom);
        send_item(CMD_PIXEL, 8'hff, $urandom);
    endtask

    // Items arriving in the wrong phase, in both phases, and a palette write
    // mid-replay
    task automatic test_wrong_phase();
        send_item(CMD_UNUSED, CODE_W'($urandom), $urandom);
        send_item(CMD_REPLAY, pick_code(), $urandom);
        // The column already sits past the new width, so the next pixel ends the row
        configure(10'd2, 10'd2, 10'd1);
        send_item(CMD_PIXEL, pick_code(), $urandom);
        send_item(CMD_PIXEL, pick_code(), $urandom);
        send_item(CMD_UNUSED, CODE_W'($urandom), $urandom);
        send_item(CMD_PALETTE, CODE_W'($urandom), $urandom);
        send_item(CMD_REPLAY, CODE_W'($urandom), $urandom);
        send_item(CMD_REPLAY, CODE_W'($urandom), $urandom);
    endtask

    // Register values at and beyond their limits: zero, maximum scale with the
    // longest replay, and a width beyond the store that keeps the row open
    task automatic test_register_limits();
        int unsigned n;
        configure(10'd0, 10'd0, 10'd0);
        send_item(CMD_PIXEL, pick_code(), $urandom);
        configure(10'd15, 10'd1, 10'd1);
        send_item(CMD_PIXEL, pick_code(), $urandom);
        for (n = 0; n < 7; n++)
            send_item(CMD_REPLAY, CODE_W'($urandom), $urandom);
        configure(10'd1, 10'h3ff, 10'd1);
        for (n = 0; n < 16; n++)
            send_item(CMD_PIXEL, pick_code(), $urandom);
    endtask

    // Frames under changing settings. Mostly the command the phase calls for, with
    // some palette writes and misplaced items mixed in. Settings change at idle
    // points, often mid-frame.
    task automatic test_random_frames();
        int unsigned chunk;
        int unsigned n;
        int unsigned roll;
        logic [CFG_W-1:0] scale;
        for (chunk = 0; chunk < 6; chunk++)
        begin
            src_calm = ($urandom_range(0, 3) == 0);
            snk_calm = ($urandom_range(0, 3) == 0);
            case (chunk)
                0: configure(10'd8, 10'd3, 10'd2);
                1: configure(10'd1, CFG_W'($urandom_range(1, 10)), 10'd512);
                default:
                begin
                    roll  = $urandom_range(0, 9);
                    scale = (roll == 0) ? 10'd0 :
                            (roll == 1) ? 10'd15 : CFG_W'($urandom_range(1, 8));
                    configure(scale, CFG_W'($urandom_range(1, 10)),
                              ($urandom_range(0, 4) == 0) ? 10'd512
                                                          : CFG_W'($urandom_range(1, 4)));
                end
            endcase
            for (n = 0; n < 14; n++)
            begin
                roll = $urandom_range(0, 99);
                if (roll < 8)
                    send_item(CMD_PALETTE, CODE_W'($urandom), $urandom);
                else if (roll < 12)
                    send_item(CMD_UNUSED, CODE_W'($urandom), $urandom);
                else if (roll < 16)
                    send_item(replaying ? CMD_PIXEL : CMD_REPLAY, pick_code(), $urandom);
                else
                    send_item(replaying ? CMD_REPLAY : CMD_PIXEL, pick_code(), $urandom);
            end
        end
        src_calm = 1'b0;
        snk_calm = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Output side: random back-pressure and the check of every pixel taken
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : check_output
        pixel_out_t want;
        if (m_tvalid === 1'b1 && m_tready === 1'b1)
        begin
            pixels_checked++;
            if (m_tuser[2] === 1'b1)
                rejects_seen++;
            if (expected_pixels.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: unexpected pixel color %h last %b flags %b",
                             $realtime, m_tdata, m_tlast, m_tuser);
            end
            else
            begin
                want = expected_pixels.pop_front();
                if (m_tdata !== want.color || m_tlast !== want.last ||
                    m_tuser[0] !== want.eol || m_tuser[1] !== want.eof ||
                    m_tuser[2] !== want.err)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"%0t: pixel %0d want color %h last %b eol %b eof %b ",
                                  "err %b, got color %h last %b eol %b eof %b err %b"},
                                 $realtime, pixels_checked, want.color, want.last, want.eol,
                                 want.eof, want.err, m_tdata, m_tlast, m_tuser[0],
                                 m_tuser[1], m_tuser[2]);
                end
            end
            sink_wait = snk_calm ? 0 : $urandom_range(0, 19);
        end
        else if (sink_wait != 0)
            sink_wait--;
        m_tready <= (sink_wait == 0);
    end

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_settings();
        test_wrong_phase();
        test_register_limits();
        test_random_frames();
        wait_drained();

        $display("Sent %0d items over %0d register settings; checked %0d pixels, %0d rejects",
                 items_sent, settings_used, pixels_checked, rejects_seen);
        $display("Mismatches: %0d", mismatches);
        if (mismatches == 0 && expected_pixels.size() == 0)
            $display("PASS palette_nearest_neighbor_upscaler_unit");
        else
            $display("FAIL palette_nearest_neighbor_upscaler_unit");
        $finish;
    end

endmodule
